@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define BTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that cond is never true at a clock edge outside reset.
`define BTC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define BTC_ASSERT(label, prop, msg)
`define BTC_ASSERT_NEVER(label, cond, msg)

`endif

`endif

@@ sv/btc_pkg.sv @@
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types, codes and constants of the teleoperation coupling block.
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int POS_W     = 32;
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 24;
  localparam int RATE_W    = 14;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_AXES  = 3;

  // Datapath widths: spring error and velocity difference, multiplier
  // operands, products, scaled velocity and accumulators.
  localparam int OPA_W  = POS_W + 4;
  localparam int OPB_W  = GAIN_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int VD_W   = POS_W + RATE_W + 4;
  localparam int ACC_W  = VD_W + 6;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef pos_t [NUM_AXES-1:0] vec3_t;
  typedef logic [1:0] axis_t;

  localparam axis_t LAST_AXIS = axis_t'(NUM_AXES - 1);

  localparam logic [GAIN_W-1:0] MASTER_STIFFNESS_RST = GAIN_W'(167772);
  localparam logic [GAIN_W-1:0] MASTER_DAMPING_RST   = GAIN_W'(1678);
  localparam logic [GAIN_W-1:0] SLAVE_STIFFNESS_RST  = GAIN_W'(167772);
  localparam logic [GAIN_W-1:0] SLAVE_DAMPING_RST    = GAIN_W'(1678);
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST      = RATE_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_STIFFNESS = 3'd0,
    REG_MASTER_DAMPING   = 3'd1,
    REG_SLAVE_STIFFNESS  = 3'd2,
    REG_SLAVE_DAMPING    = 3'd3,
    REG_SAMPLE_RATE      = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_LOCK   = 2'd1,
    BTN_COUPLE = 2'd2
  } button_e;

  typedef enum logic [1:0] {
    STATUS_IDLE     = 2'd0,
    STATUS_ACTIVE   = 2'd1,
    STATUS_RELEASED = 2'd2
  } status_e;

  // Steps of the per-axis spring-damper sequence.
  typedef enum logic [2:0] {
    PH_LOAD    = 3'd0,
    PH_VEL_MUL = 3'd1,
    PH_VEL     = 3'd2,
    PH_HI      = 3'd3,
    PH_LO      = 3'd4,
    PH_SUM     = 3'd5
  } phase_e;

  typedef struct packed {
    logic [GAIN_W-1:0] master_stiffness;
    logic [GAIN_W-1:0] master_damping;
    logic [GAIN_W-1:0] slave_stiffness;
    logic [GAIN_W-1:0] slave_damping;
    logic [RATE_W-1:0] sample_rate_hz;
  } cfg_t;

  typedef struct packed {
    logic    capture;
    logic    latch_anchor;
    logic    calc;
    axis_t   axis;
    phase_e  phase;
    logic    finish;
    status_e status;
    logic    lock;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Clamp an accumulator value to the signed position range.
  function automatic pos_t sat_pos(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:POS_W-1]) | ~(|v[ACC_W-1:POS_W-1]);
    if (fits) begin
      return pos_t'(v[POS_W-1:0]);
    end else if (v[ACC_W-1]) begin
      return pos_t'({1'b1, {(POS_W-1){1'b0}}});
    end else begin
      return pos_t'({1'b0, {(POS_W-1){1'b1}}});
    end
  endfunction

endpackage

@@ sv/btc_ctrl.sv @@
// ----------------------------------------------------------------------------
// btc_ctrl
// Sequencer: button handling, coupling and lock state, per-axis step control.
// ----------------------------------------------------------------------------
module btc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           button_code_i,
  input  btc_pkg::stat_t       stat_i,
  output btc_pkg::cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CALC = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  state_e            state_q;
  btc_pkg::axis_t    axis_q;
  btc_pkg::phase_e   phase_q;
  btc_pkg::status_e  status_q;
  btc_pkg::status_e  status_d;
  logic              coupled_q;
  logic              coupled_d;
  logic              lock_q;
  logic              accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Coupling toggle and resulting status for the transaction being accepted.
  always_comb begin
    coupled_d = coupled_q;
    status_d  = coupled_q ? btc_pkg::STATUS_ACTIVE : btc_pkg::STATUS_IDLE;
    case (btc_pkg::button_e'(button_code_i))
      btc_pkg::BTN_COUPLE: begin
        coupled_d = !coupled_q;
        status_d  = coupled_q ? btc_pkg::STATUS_RELEASED : btc_pkg::STATUS_ACTIVE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      axis_q    <= '0;
      phase_q   <= btc_pkg::PH_LOAD;
      status_q  <= btc_pkg::STATUS_IDLE;
      coupled_q <= 1'b0;
      lock_q    <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            coupled_q <= coupled_d;
            status_q  <= status_d;
            axis_q    <= '0;
            phase_q   <= btc_pkg::PH_LOAD;
            if (btc_pkg::button_e'(button_code_i) == btc_pkg::BTN_LOCK) begin
              lock_q <= !lock_q;
            end
            state_q <= coupled_d ? S_CALC : S_FIN;
          end
        end
        S_CALC: begin
          case (phase_q)
            btc_pkg::PH_LOAD:    phase_q <= btc_pkg::PH_VEL_MUL;
            btc_pkg::PH_VEL_MUL: phase_q <= btc_pkg::PH_VEL;
            btc_pkg::PH_VEL:     phase_q <= btc_pkg::PH_HI;
            btc_pkg::PH_HI:      phase_q <= btc_pkg::PH_LO;
            btc_pkg::PH_LO:      phase_q <= btc_pkg::PH_SUM;
            default: begin
              phase_q <= btc_pkg::PH_LOAD;
              if (axis_q == btc_pkg::LAST_AXIS) begin
                state_q <= S_FIN;
              end else begin
                axis_q <= axis_q + 2'd1;
              end
            end
          endcase
        end
        S_FIN: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.capture      = accept;
    cmd_o.latch_anchor = accept &&
                         (btc_pkg::button_e'(button_code_i) == btc_pkg::BTN_COUPLE) &&
                         !coupled_q;
    cmd_o.calc         = (state_q == S_CALC);
    cmd_o.axis         = axis_q;
    cmd_o.phase        = phase_q;
    cmd_o.finish       = (state_q == S_FIN) && stat_i.out_free;
    cmd_o.status       = status_q;
    cmd_o.lock         = lock_q;
  end

endmodule

@@ sv/btc_datapath.sv @@
// ----------------------------------------------------------------------------
// btc_datapath
// Sample and anchor storage, two gain multipliers, accumulators, output stage.
// ----------------------------------------------------------------------------
module btc_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  btc_pkg::cfg_t   cfg_i,
  input  btc_pkg::cmd_t   cmd_i,
  output btc_pkg::stat_t  stat_o,
  input  btc_pkg::vec3_t  haptic_i,
  input  btc_pkg::vec3_t  robot_i,
  input  btc_pkg::vec3_t  rotation_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [1:0]      status_o,
  output btc_pkg::vec3_t  force_o,
  output btc_pkg::vec3_t  command_o,
  output btc_pkg::vec3_t  rotation_o,
  output logic            orientation_locked_o
);

  localparam int OPA_W  = btc_pkg::OPA_W;
  localparam int OPB_W  = btc_pkg::OPB_W;
  localparam int PROD_W = btc_pkg::PROD_W;
  localparam int VD_W   = btc_pkg::VD_W;
  localparam int ACC_W  = btc_pkg::ACC_W;
  localparam int FRAC   = btc_pkg::GAIN_FRAC;

  // Tick samples, anchors and previous samples.
  btc_pkg::vec3_t hap_q, rob_q, rot_q;
  btc_pkg::vec3_t hanc_q, ranc_q;
  btc_pkg::vec3_t prevh_q, prevr_q;

  // Per-axis working registers.
  logic signed [OPA_W-1:0]  d_q, d_d;
  logic signed [OPA_W-1:0]  vdiff_q, vdiff_d;
  logic signed [VD_W-1:0]   vd_q, nvd, vd_shr, nvd_shr;
  logic signed [PROD_W-1:0] pa_q, pa_d, pb_q, pb_d, pa_shr, pb_shr;
  logic signed [ACC_W-1:0]  acc_a_q, acc_b_q, sum_a, sum_b;
  logic signed [ACC_W-1:0]  pa_shr_acc, pb_shr_acc, pa_acc, pb_acc;
  btc_pkg::vec3_t           force_res_q, cmd_res_q;

  // Multiplier operands: lane a builds the force, lane b the command.
  logic signed [OPA_W-1:0]  opa_a, opa_b;
  logic signed [OPB_W-1:0]  opb_a, opb_b;
  logic signed [OPB_W-1:0]  km, bm, ks, bs, rate;
  logic signed [OPA_W-1:0]  vd_hi, nvd_hi, vd_lo, nvd_lo;

  btc_pkg::pos_t h_sel, r_sel, ha_sel, ra_sel, ph_sel, pr_sel;

  // Output stage.
  logic            out_valid_q;
  logic [1:0]      status_q;
  logic            lock_q;
  btc_pkg::vec3_t  force_q, command_q, rotout_q;

  assign h_sel  = btc_pkg::pos_t'(hap_q[cmd_i.axis]);
  assign r_sel  = btc_pkg::pos_t'(rob_q[cmd_i.axis]);
  assign ha_sel = btc_pkg::pos_t'(hanc_q[cmd_i.axis]);
  assign ra_sel = btc_pkg::pos_t'(ranc_q[cmd_i.axis]);
  assign ph_sel = btc_pkg::pos_t'(prevh_q[cmd_i.axis]);
  assign pr_sel = btc_pkg::pos_t'(prevr_q[cmd_i.axis]);

  // Spring error Xm - Xs and position difference behind Vh - Vs.
  assign d_d     = OPA_W'(ra_sel) + OPA_W'(h_sel) - OPA_W'(ha_sel) - OPA_W'(r_sel);
  assign vdiff_d = OPA_W'(h_sel) - OPA_W'(ph_sel) - OPA_W'(r_sel) + OPA_W'(pr_sel);

  assign km   = $signed({1'b0, cfg_i.master_stiffness});
  assign bm   = $signed({1'b0, cfg_i.master_damping});
  assign ks   = $signed({1'b0, cfg_i.slave_stiffness});
  assign bs   = $signed({1'b0, cfg_i.slave_damping});
  assign rate = $signed({{(OPB_W-btc_pkg::RATE_W){1'b0}}, cfg_i.sample_rate_hz});

  // Split the wide velocity term into a high part and an unsigned low part.
  assign nvd     = -vd_q;
  assign vd_shr  = vd_q >>> FRAC;
  assign nvd_shr = nvd >>> FRAC;
  assign vd_hi   = $signed(vd_shr[OPA_W-1:0]);
  assign nvd_hi  = $signed(nvd_shr[OPA_W-1:0]);
  assign vd_lo   = $signed({{(OPA_W-FRAC){1'b0}}, vd_q[FRAC-1:0]});
  assign nvd_lo  = $signed({{(OPA_W-FRAC){1'b0}}, nvd[FRAC-1:0]});

  always_comb begin
    opa_a = '0;
    opb_a = '0;
    opa_b = '0;
    opb_b = '0;
    case (cmd_i.phase)
      btc_pkg::PH_VEL_MUL: begin
        opa_a = vdiff_q;
        opb_a = rate;
        opa_b = d_q;
        opb_b = ks;
      end
      btc_pkg::PH_VEL: begin
        opa_a = -d_q;
        opb_a = km;
      end
      btc_pkg::PH_HI: begin
        opa_a = nvd_hi;
        opb_a = bm;
        opa_b = vd_hi;
        opb_b = bs;
      end
      btc_pkg::PH_LO: begin
        opa_a = nvd_lo;
        opb_a = bm;
        opa_b = vd_lo;
        opb_b = bs;
      end
      default: ;
    endcase
  end

  assign pa_d = opa_a * opb_a;
  assign pb_d = opa_b * opb_b;

  assign pa_shr     = pa_q >>> FRAC;
  assign pb_shr     = pb_q >>> FRAC;
  assign pa_shr_acc = $signed(pa_shr[ACC_W-1:0]);
  assign pb_shr_acc = $signed(pb_shr[ACC_W-1:0]);
  assign pa_acc     = $signed(pa_q[ACC_W-1:0]);
  assign pb_acc     = $signed(pb_q[ACC_W-1:0]);
  assign sum_a      = acc_a_q + pa_shr_acc;
  assign sum_b      = acc_b_q + pb_shr_acc;

  // Control part: previous samples and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prevh_q     <= '0;
      prevr_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      prevh_q     <= hap_q;
      prevr_q     <= rob_q;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hap_q <= haptic_i;
      rob_q <= robot_i;
      rot_q <= rotation_i;
    end
    if (cmd_i.latch_anchor) begin
      hanc_q <= haptic_i;
      ranc_q <= robot_i;
    end
    pa_q <= pa_d;
    pb_q <= pb_d;
    if (cmd_i.calc) begin
      case (cmd_i.phase)
        btc_pkg::PH_LOAD: begin
          d_q     <= d_d;
          vdiff_q <= vdiff_d;
        end
        btc_pkg::PH_VEL: begin
          vd_q    <= $signed(pa_q[VD_W-1:0]);
          acc_b_q <= ACC_W'(r_sel) + pb_shr_acc;
        end
        btc_pkg::PH_HI: begin
          acc_a_q <= pa_shr_acc;
        end
        btc_pkg::PH_LO: begin
          acc_a_q <= acc_a_q + pa_acc;
          acc_b_q <= acc_b_q + pb_acc;
        end
        btc_pkg::PH_SUM: begin
          force_res_q[cmd_i.axis] <= btc_pkg::sat_pos(sum_a);
          cmd_res_q[cmd_i.axis]   <= btc_pkg::sat_pos(sum_b);
        end
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      lock_q   <= cmd_i.lock;
      if (cmd_i.status == btc_pkg::STATUS_ACTIVE) begin
        force_q   <= force_res_q;
        command_q <= cmd_res_q;
        rotout_q  <= rot_q;
      end else begin
        force_q   <= '0;
        command_q <= '0;
        rotout_q  <= '0;
      end
    end
  end

  assign stat_o.out_free      = !out_valid_q || out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign force_o              = force_q;
  assign command_o            = command_q;
  assign rotation_o           = rotout_q;
  assign orientation_locked_o = lock_q;

endmodule

@@ sv/bilateral_teleop_coupling.sv @@
// ----------------------------------------------------------------------------
// bilateral_teleop_coupling
// Position-position bilateral coupling of a haptic master and a robot slave.
// ----------------------------------------------------------------------------
// Each input transaction is one sample tick (haptic xyz, robot xyz, robot W/P/R
// rotation, button code) and produces exactly one result transaction. Button
// code 2 toggles coupling: engaging latches the haptic and robot anchors,
// disengaging returns one result with status 2 and zero force; code 1 toggles
// the reported orientation lock (reset: locked). While coupled, each axis gets
// a spring-damper force for the haptic device and a corrected robot position,
// all Q15.16 and saturated to 32 bits; the rotation is copied through. Gains
// are unsigned Q0.24 and velocities are sample differences times
// sample_rate_hz. A coupled tick runs six sequencer steps per axis on the
// shared pair of 36x25 gain multipliers (one for the force, one for the
// command); an uncoupled tick goes straight to the final step. The tick is
// captured on acceptance, and the final step loads the result into the output
// register. A finished result sits in the output register, so the next tick
// is accepted while the result still waits to be taken; the block holds in its
// final step only if the previous result was not taken. Configuration
// registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Indices beyond the list are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bilateral_teleop_coupling (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [btc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [btc_pkg::GAIN_W-1:0]        cfg_wdata_i,
  // sample tick input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [btc_pkg::POS_W-1:0]  haptic_x_i,
  input  logic signed [btc_pkg::POS_W-1:0]  haptic_y_i,
  input  logic signed [btc_pkg::POS_W-1:0]  haptic_z_i,
  input  logic signed [btc_pkg::POS_W-1:0]  robot_x_i,
  input  logic signed [btc_pkg::POS_W-1:0]  robot_y_i,
  input  logic signed [btc_pkg::POS_W-1:0]  robot_z_i,
  input  logic signed [btc_pkg::POS_W-1:0]  robot_roll_w_i,
  input  logic signed [btc_pkg::POS_W-1:0]  robot_pitch_p_i,
  input  logic signed [btc_pkg::POS_W-1:0]  robot_yaw_r_i,
  input  logic [1:0]                        button_code_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [btc_pkg::POS_W-1:0]  force_x_o,
  output logic signed [btc_pkg::POS_W-1:0]  force_y_o,
  output logic signed [btc_pkg::POS_W-1:0]  force_z_o,
  output logic signed [btc_pkg::POS_W-1:0]  command_x_o,
  output logic signed [btc_pkg::POS_W-1:0]  command_y_o,
  output logic signed [btc_pkg::POS_W-1:0]  command_z_o,
  output logic signed [btc_pkg::POS_W-1:0]  command_w_o,
  output logic signed [btc_pkg::POS_W-1:0]  command_p_o,
  output logic signed [btc_pkg::POS_W-1:0]  command_r_o,
  output logic                              orientation_locked_o
);

  btc_pkg::cfg_t   cfg_q;
  btc_pkg::cmd_t   cmd;
  btc_pkg::stat_t  stat;
  btc_pkg::vec3_t  force_w, command_w, rotation_w;

  // Configuration registers; writes to unknown indices are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.master_stiffness <= btc_pkg::MASTER_STIFFNESS_RST;
      cfg_q.master_damping   <= btc_pkg::MASTER_DAMPING_RST;
      cfg_q.slave_stiffness  <= btc_pkg::SLAVE_STIFFNESS_RST;
      cfg_q.slave_damping    <= btc_pkg::SLAVE_DAMPING_RST;
      cfg_q.sample_rate_hz   <= btc_pkg::SAMPLE_RATE_RST;
    end else if (cfg_we_i) begin
      case (btc_pkg::cfg_reg_e'(cfg_idx_i))
        btc_pkg::REG_MASTER_STIFFNESS: cfg_q.master_stiffness <= cfg_wdata_i;
        btc_pkg::REG_MASTER_DAMPING:   cfg_q.master_damping   <= cfg_wdata_i;
        btc_pkg::REG_SLAVE_STIFFNESS:  cfg_q.slave_stiffness  <= cfg_wdata_i;
        btc_pkg::REG_SLAVE_DAMPING:    cfg_q.slave_damping    <= cfg_wdata_i;
        btc_pkg::REG_SAMPLE_RATE: begin
          cfg_q.sample_rate_hz <= cfg_wdata_i[btc_pkg::RATE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Sequencer: owns coupling and lock state, steps the datapath per axis.
  btc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .button_code_i (button_code_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Datapath: axis 0 is x, 1 is y, 2 is z (rotation: W, P, R).
  btc_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .haptic_i             ({haptic_z_i, haptic_y_i, haptic_x_i}),
    .robot_i              ({robot_z_i, robot_y_i, robot_x_i}),
    .rotation_i           ({robot_yaw_r_i, robot_pitch_p_i, robot_roll_w_i}),
    .out_ready_i          (out_ready_i),
    .out_valid_o          (out_valid_o),
    .status_o             (status_o),
    .force_o              (force_w),
    .command_o            (command_w),
    .rotation_o           (rotation_w),
    .orientation_locked_o (orientation_locked_o)
  );

  assign force_x_o   = force_w[0];
  assign force_y_o   = force_w[1];
  assign force_z_o   = force_w[2];
  assign command_x_o = command_w[0];
  assign command_y_o = command_w[1];
  assign command_z_o = command_w[2];
  assign command_w_o = rotation_w[0];
  assign command_p_o = rotation_w[1];
  assign command_r_o = rotation_w[2];

  // One transaction in flight: accepting drops ready on the next cycle.
  `BTC_ASSERT(a_single_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second transaction accepted while busy")

  // Never load a new result over one that is neither empty nor being taken.
  `BTC_ASSERT(a_no_result_overwrite, cmd.finish |-> (!out_valid_o || out_ready_i), "result register overwritten")

  // Never accept a tick in the same cycle a result is being loaded.
  `BTC_ASSERT_NEVER(a_no_accept_at_finish, in_valid_i && in_ready_o && cmd.finish, "accept during result load")

  // A release result carries zero force and zero command.
  `BTC_ASSERT(a_release_zero, (out_valid_o && (status_o == btc_pkg::STATUS_RELEASED)) |-> ((force_x_o == '0) && (command_x_o == '0) && (command_w_o == '0)), "release result not zero")

endmodule

@@ verif/btc_checker.sv @@
// ----------------------------------------------------------------------------
// btc_checker
// Predicts and checks every sample tick of the teleoperation coupling block.
// ----------------------------------------------------------------------------
// Watches the configuration port and both handshake channels. Each accepted
// input transaction runs through a cycle-free model of the coupling law. The
// expected result is queued, and each accepted result is compared field by
// field with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btc_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [btc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [btc_pkg::GAIN_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  btc_pkg::vec3_t                   haptic_i,
  input  btc_pkg::vec3_t                   robot_i,
  input  btc_pkg::vec3_t                   rotation_i,
  input  logic [1:0]                       button_code_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [1:0]                       status_i,
  input  btc_pkg::vec3_t                   feedback_i,
  input  btc_pkg::vec3_t                   command_i,
  input  btc_pkg::vec3_t                   command_rot_i,
  input  logic                             orientation_locked_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import btc_pkg::*;

  typedef struct packed {
    status_e status;
    vec3_t   feedback;
    vec3_t   command;
    vec3_t   rotation;
    logic    locked;
  } tick_result_t;

  tick_result_t expected_q[$];
  int failures = 0;

  logic [GAIN_W-1:0] k_master, b_master, k_slave, b_slave;
  logic [RATE_W-1:0] rate_hz;
  longint last_haptic[NUM_AXES], last_robot[NUM_AXES];
  longint anchor_haptic[NUM_AXES], anchor_robot[NUM_AXES];
  logic coupled, locked;

  string axis_tag[NUM_AXES] = '{"x", "y", "z"};
  string rot_tag[NUM_AXES]  = '{"w", "p", "r"};

  assign fail_count_o = failures;
  assign pending_o    = expected_q.size();

  // floor(v * g / 2^GAIN_FRAC); operands here stay far below the clamp point
  function automatic longint gain_mul(input longint v, input logic [GAIN_W-1:0] g);
    logic signed [95:0] wide;
    wide = v * $signed({1'b0, g});
    return longint'(wide >>> GAIN_FRAC);
  endfunction

  function automatic pos_t clamp_q16(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < longint'(32'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return pos_t'(v);
  endfunction

  // Advance the coupling state by one sample tick and return its result.
  function automatic tick_result_t couple_tick(input vec3_t hap, input vec3_t rob,
                                               input vec3_t rot, input logic [1:0] code);
    tick_result_t res;
    longint h, r, vh, vr, xm, fm, fs, rate_l;
    logic released;
    res      = '0;
    released = 1'b0;
    rate_l   = rate_hz;
    case (code)
      BTN_COUPLE: begin
        if (!coupled) begin
          coupled = 1'b1;
          for (int ax = 0; ax < NUM_AXES; ax++) begin
            anchor_haptic[ax] = $signed(hap[ax]);
            anchor_robot[ax]  = $signed(rob[ax]);
          end
        end else begin
          coupled  = 1'b0;
          released = 1'b1;
        end
      end
      BTN_LOCK: locked = !locked;
      default: ;
    endcase
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      h  = $signed(hap[ax]);
      r  = $signed(rob[ax]);
      vh = (h - last_haptic[ax]) * rate_l;
      vr = (r - last_robot[ax]) * rate_l;
      if (coupled) begin
        xm = anchor_robot[ax] + (h - anchor_haptic[ax]);
        fm = gain_mul(r - xm, k_master) + gain_mul(vr - vh, b_master);
        fs = gain_mul(xm - r, k_slave) + gain_mul(vh - vr, b_slave);
        res.feedback[ax] = clamp_q16(fm);
        res.command[ax]  = clamp_q16(r + fs);
        res.rotation[ax] = rot[ax];
      end
      last_haptic[ax] = h;
      last_robot[ax]  = r;
    end
    res.status = coupled ? STATUS_ACTIVE : (released ? STATUS_RELEASED : STATUS_IDLE);
    res.locked = locked;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t exp_res;
    if (!rst_ni) begin
      k_master = MASTER_STIFFNESS_RST;
      b_master = MASTER_DAMPING_RST;
      k_slave  = SLAVE_STIFFNESS_RST;
      b_slave  = SLAVE_DAMPING_RST;
      rate_hz  = SAMPLE_RATE_RST;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        last_haptic[ax]   = 0;
        last_robot[ax]    = 0;
        anchor_haptic[ax] = 0;
        anchor_robot[ax]  = 0;
      end
      coupled = 1'b0;
      locked  = 1'b1;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MASTER_STIFFNESS: k_master = cfg_wdata_i;
          REG_MASTER_DAMPING:   b_master = cfg_wdata_i;
          REG_SLAVE_STIFFNESS:  k_slave  = cfg_wdata_i;
          REG_SLAVE_DAMPING:    b_slave  = cfg_wdata_i;
          REG_SAMPLE_RATE:      rate_hz  = cfg_wdata_i[RATE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no sample tick pending");
          failures++;
        end else begin
          exp_res = expected_q.pop_front();
          check_field("status", POS_W'(exp_res.status), POS_W'(status_i));
          for (int ax = 0; ax < NUM_AXES; ax++) begin
            check_field({"force_", axis_tag[ax]}, exp_res.feedback[ax], feedback_i[ax]);
            check_field({"command_", axis_tag[ax]}, exp_res.command[ax], command_i[ax]);
            check_field({"command_", rot_tag[ax]}, exp_res.rotation[ax],
                        command_rot_i[ax]);
          end
          check_field("orientation_locked", POS_W'(exp_res.locked),
                      POS_W'(orientation_locked_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(couple_tick(haptic_i, robot_i, rotation_i, button_code_i));
      end
    end
  end

endmodule

@@ verif/tb_bilateral_teleop_coupling.sv @@
// ----------------------------------------------------------------------------
// tb_bilateral_teleop_coupling
// Stimulus and verdict for the bilateral teleoperation coupling block.
// ----------------------------------------------------------------------------
// Drives sample ticks through the valid/ready input, stalls the result side at
// random and walks the gain and sample-rate registers through several
// settings, the extremes among them. A directed burst covers the button codes,
// engage/release and saturation; random ticks follow, mostly random walks
// around the current pose with coupling toggled about every sixteen ticks.
// Prediction and comparison live in btc_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bilateral_teleop_coupling;
  import btc_pkg::*;

  // Button code 3 is not a named code of the block; it must act as no button.
  localparam logic [1:0] BTN_SPARE = 2'd3;
  localparam pos_t POS_MAX   = 32'sh7FFF_FFFF;
  localparam pos_t POS_MIN   = 32'sh8000_0000;
  localparam pos_t WALK_STEP = 32'sd262144;  // 4 mm in Q15.16

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [GAIN_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  vec3_t                hap_drive, rob_drive, robot_rot;
  logic [1:0]           button_code_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           status_o;
  vec3_t                feedback_w, command_w, command_rot_w;
  logic                 orientation_locked_o;

  int  failures;
  int  pending;
  bit  steady_run;

  bilateral_teleop_coupling dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .haptic_x_i           (hap_drive[0]),
    .haptic_y_i           (hap_drive[1]),
    .haptic_z_i           (hap_drive[2]),
    .robot_x_i            (rob_drive[0]),
    .robot_y_i            (rob_drive[1]),
    .robot_z_i            (rob_drive[2]),
    .robot_roll_w_i       (robot_rot[0]),
    .robot_pitch_p_i      (robot_rot[1]),
    .robot_yaw_r_i        (robot_rot[2]),
    .button_code_i        (button_code_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .status_o             (status_o),
    .force_x_o            (feedback_w[0]),
    .force_y_o            (feedback_w[1]),
    .force_z_o            (feedback_w[2]),
    .command_x_o          (command_w[0]),
    .command_y_o          (command_w[1]),
    .command_z_o          (command_w[2]),
    .command_w_o          (command_rot_w[0]),
    .command_p_o          (command_rot_w[1]),
    .command_r_o          (command_rot_w[2]),
    .orientation_locked_o (orientation_locked_o)
  );

  btc_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .haptic_i             (hap_drive),
    .robot_i              (rob_drive),
    .rotation_i           (robot_rot),
    .button_code_i        (button_code_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .status_i             (status_o),
    .feedback_i           (feedback_w),
    .command_i            (command_w),
    .command_rot_i        (command_rot_w),
    .orientation_locked_i (orientation_locked_o),
    .fail_count_o         (failures),
    .pending_o            (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stall the result side with a probability of about 12 in 100, except during a steady run.
  always @(negedge clk_i) begin
    out_ready_i <= steady_run || ($urandom_range(99) >= 12);
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic vec3_t vec(input pos_t x, input pos_t y, input pos_t z);
    vec3_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    return v;
  endfunction

  // Mostly a small random walk; sometimes a jump anywhere, near a range edge, or to zero or minus one.
  function automatic pos_t step_position(input pos_t p);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return p + pos_t'($urandom_range(2 * WALK_STEP)) - WALK_STEP;
    end else if (pick < 85) begin
      return pos_t'($urandom);
    end
    case ($urandom_range(3))
      0: return POS_MAX - pos_t'($urandom_range(255));
      1: return POS_MIN + pos_t'($urandom_range(255));
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Present one sample tick and hold it until the block takes it.
  task automatic drive_tick(input vec3_t hap, input vec3_t rob, input vec3_t rot,
                            input logic [1:0] code);
    @(negedge clk_i);
    while (!steady_run && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    hap_drive     <= hap;
    rob_drive     <= rob;
    robot_rot     <= rot;
    button_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and let every outstanding result come back.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic apply_gains(input logic [GAIN_W-1:0] km, input logic [GAIN_W-1:0] bm,
                             input logic [GAIN_W-1:0] ks, input logic [GAIN_W-1:0] bs,
                             input logic [RATE_W-1:0] rate);
    write_reg(REG_MASTER_STIFFNESS, km);
    write_reg(REG_MASTER_DAMPING, bm);
    write_reg(REG_SLAVE_STIFFNESS, ks);
    write_reg(REG_SLAVE_DAMPING, bs);
    write_reg(REG_SAMPLE_RATE, GAIN_W'(rate));
  endtask

  // Random ticks: coupling toggles in about 6 of 100, lock in 6, spare code in 4.
  task automatic run_random(input int count);
    vec3_t hap, rob, rot;
    logic [1:0] code;
    int unsigned pick;
    hap = hap_drive;
    rob = rob_drive;
    for (int n = 0; n < count; n++) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        hap[ax] = step_position(hap[ax]);
        rob[ax] = step_position(rob[ax]);
        rot[ax] = pos_t'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 6) begin
        code = BTN_COUPLE;
      end else if (pick < 12) begin
        code = BTN_LOCK;
      end else if (pick < 16) begin
        code = BTN_SPARE;
      end else begin
        code = BTN_NONE;
      end
      drive_tick(hap, rob, rot, code);
    end
  endtask

  initial begin : stimulus
    // Hold every input at a known value through reset.
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MASTER_STIFFNESS;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    hap_drive     = '0;
    rob_drive     = '0;
    robot_rot     = '0;
    button_code_i = BTN_NONE;
    out_ready_i   = 1'b0;
    steady_run    = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed burst at reset settings. First tick sees zero previous samples.
    drive_tick(vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, 0), BTN_NONE);
    drive_tick(vec(POS_MAX, POS_MAX, POS_MAX), vec(POS_MIN, POS_MIN, POS_MIN),
               vec(POS_MAX, POS_MIN, POS_MAX), BTN_SPARE);
    drive_tick(vec(100, -200, 300), vec(-5, 6, -7), vec(1, 2, 3), BTN_LOCK);
    drive_tick(vec(101, -201, 301), vec(-4, 7, -6), vec(1, 2, 3), BTN_LOCK);
    // Engage with anchors at opposite range edges, then swing to the far edges.
    drive_tick(vec(POS_MAX, POS_MAX, POS_MAX), vec(POS_MIN, POS_MIN, POS_MIN),
               vec(POS_MIN, POS_MAX, POS_MIN), BTN_COUPLE);
    drive_tick(vec(POS_MIN, POS_MIN, POS_MIN), vec(POS_MAX, POS_MAX, POS_MAX),
               vec(POS_MAX, POS_MIN, -1), BTN_NONE);
    drive_tick(vec(-1, 0, 1), vec(0, -1, 0), vec(-1, -1, -1), BTN_LOCK);
    drive_tick(vec(-1, 0, 1), vec(0, -1, 0), vec(0, 0, 0), BTN_SPARE);
    drive_tick(vec(65536, -65536, 131072), vec(0, 0, 0), vec(7, 8, 9), BTN_NONE);
    drive_tick(vec(65536, -65536, 131072), vec(0, 0, 0), vec(7, 8, 9), BTN_COUPLE);
    drive_tick(vec(0, 0, 0), vec(0, 0, 0), vec(7, 8, 9), BTN_NONE);
    // Engage and release on back-to-back ticks.
    drive_tick(vec(1000, 2000, 3000), vec(-1000, -2000, -3000), vec(4, 5, 6), BTN_COUPLE);
    drive_tick(vec(1000, 2000, 3000), vec(-1000, -2000, -3000), vec(4, 5, 6), BTN_COUPLE);
    drive_tick(vec(0, 65536, 0), vec(65536, 0, 0), vec(POS_MAX, 0, POS_MIN), BTN_COUPLE);
    drive_tick(vec(262144, 65536, 0), vec(65536, -262144, 0), vec(1, 1, 1), BTN_NONE);
    drive_tick(vec(-262144, 65536, 32768), vec(65536, 262144, 0), vec(2, 2, 2), BTN_NONE);
    drive_tick(vec(0, 0, 0), vec(0, 0, 0), vec(3, 3, 3), BTN_COUPLE);
    run_random(240);

    // Every gain at full scale, sample rate past its nominal top, and junk
    // writes to indices beyond the register list.
    drain_block();
    apply_gains('1, '1, '1, '1, '1);
    for (int idx = int'(REG_SAMPLE_RATE) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), GAIN_W'($urandom));
    end
    run_random(240);

    // Zero gains and zero sample rate: all velocities vanish.
    drain_block();
    apply_gains('0, '0, '0, '0, '0);
    run_random(200);

    // Slowest sample rate, half-scale springs; no idling on either side.
    drain_block();
    steady_run = 1'b1;
    apply_gains(24'h80_0000, 24'h10_0000, 24'h80_0000, 24'h10_0000, 14'd1);
    run_random(240);

    drain_block();
    steady_run = 1'b0;
    apply_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                GAIN_W'($urandom), 14'd10000);
    run_random(240);

    drain_block();
    apply_gains(24'd167772, 24'd1678, 24'd167772, 24'd1678,
                RATE_W'($urandom_range(1, 10000)));
    run_random(290);

    // Flush, then wait for stray results before the verdict.
    drain_block();
    repeat (40) @(posedge clk_i);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
